@@ src/ps2a_pkg.sv @@
// Package for the PS/2 set-1 scan-code decoder with receive FIFO.
// Holds operation, register and scan-code constants and the set-1 key tables.
// No dependencies.
`default_nettype none

package ps2a_pkg;

   localparam int FIFO_SLOTS_DEF = 128;

   // operation codes
   localparam logic OP_EVENT = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // register indexes
   localparam logic [1:0] CSR_ESCAPE    = 2'd0;
   localparam logic [1:0] CSR_BACKSPACE = 2'd1;
   localparam logic [1:0] CSR_TAB       = 2'd2;
   localparam logic [1:0] CSR_ENTER     = 2'd3;

   localparam logic [7:0] ESCAPE_RST    = 8'd27;
   localparam logic [7:0] BACKSPACE_RST = 8'd8;
   localparam logic [7:0] TAB_RST       = 8'd9;
   localparam logic [7:0] ENTER_RST     = 8'd10;

   // set-1 key codes (bit 7 stripped)
   localparam logic [6:0] SC_ESC    = 7'h01;
   localparam logic [6:0] SC_BKSP   = 7'h0E;
   localparam logic [6:0] SC_TAB    = 7'h0F;
   localparam logic [6:0] SC_ENTER  = 7'h1C;
   localparam logic [6:0] SC_CTRL   = 7'h1D;
   localparam logic [6:0] SC_LSHIFT = 7'h2A;
   localparam logic [6:0] SC_RSHIFT = 7'h36;
   localparam logic [6:0] SC_ALT    = 7'h38;

   localparam logic [7:0] SC_RELEASE_LSHIFT = 8'hAA;

   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_CTRL_OFFSET = 8'h60;

   typedef logic [7:0] char_type;

   function automatic char_type plain_char(input logic [6:0] code);
      char_type c;
      case (code)
         7'h02: c = 8'h31;  7'h03: c = 8'h32;  7'h04: c = 8'h33;  7'h05: c = 8'h34;
         7'h06: c = 8'h35;  7'h07: c = 8'h36;  7'h08: c = 8'h37;  7'h09: c = 8'h38;
         7'h0A: c = 8'h39;  7'h0B: c = 8'h30;  7'h0C: c = 8'h2D;  7'h0D: c = 8'h3D;
         7'h10: c = 8'h71;  7'h11: c = 8'h77;  7'h12: c = 8'h65;  7'h13: c = 8'h72;
         7'h14: c = 8'h74;  7'h15: c = 8'h79;  7'h16: c = 8'h75;  7'h17: c = 8'h69;
         7'h18: c = 8'h6F;  7'h19: c = 8'h70;  7'h1A: c = 8'h5B;  7'h1B: c = 8'h5D;
         7'h1E: c = 8'h61;  7'h1F: c = 8'h73;
         7'h20: c = 8'h64;  7'h21: c = 8'h66;  7'h22: c = 8'h67;  7'h23: c = 8'h68;
         7'h24: c = 8'h6A;  7'h25: c = 8'h6B;  7'h26: c = 8'h6C;  7'h27: c = 8'h3B;
         7'h28: c = 8'h27;  7'h29: c = 8'h60;  7'h2B: c = 8'h5C;
         7'h2C: c = 8'h7A;  7'h2D: c = 8'h78;  7'h2E: c = 8'h63;  7'h2F: c = 8'h76;
         7'h30: c = 8'h62;  7'h31: c = 8'h6E;  7'h32: c = 8'h6D;  7'h33: c = 8'h2C;
         7'h34: c = 8'h2E;  7'h35: c = 8'h2F;  7'h37: c = 8'h2A;  7'h39: c = 8'h20;
         7'h47: c = 8'h37;  7'h48: c = 8'h38;  7'h49: c = 8'h39;  7'h4A: c = 8'h2D;
         7'h4B: c = 8'h34;  7'h4C: c = 8'h35;  7'h4D: c = 8'h36;  7'h4E: c = 8'h2B;
         7'h4F: c = 8'h31;  7'h50: c = 8'h32;  7'h51: c = 8'h33;  7'h52: c = 8'h30;
         7'h53: c = 8'h2E;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic char_type shift_char(input logic [6:0] code);
      char_type c;
      case (code)
         7'h02: c = 8'h21;  7'h03: c = 8'h40;  7'h04: c = 8'h23;  7'h05: c = 8'h24;
         7'h06: c = 8'h25;  7'h07: c = 8'h5E;  7'h08: c = 8'h26;  7'h09: c = 8'h2A;
         7'h0A: c = 8'h28;  7'h0B: c = 8'h29;  7'h0C: c = 8'h5F;  7'h0D: c = 8'h2B;
         7'h10: c = 8'h51;  7'h11: c = 8'h57;  7'h12: c = 8'h45;  7'h13: c = 8'h52;
         7'h14: c = 8'h54;  7'h15: c = 8'h59;  7'h16: c = 8'h55;  7'h17: c = 8'h49;
         7'h18: c = 8'h4F;  7'h19: c = 8'h50;  7'h1A: c = 8'h7B;  7'h1B: c = 8'h7D;
         7'h1E: c = 8'h41;  7'h1F: c = 8'h53;
         7'h20: c = 8'h44;  7'h21: c = 8'h46;  7'h22: c = 8'h47;  7'h23: c = 8'h48;
         7'h24: c = 8'h4A;  7'h25: c = 8'h4B;  7'h26: c = 8'h4C;  7'h27: c = 8'h3A;
         7'h28: c = 8'h22;  7'h29: c = 8'h7E;  7'h2B: c = 8'h7C;
         7'h2C: c = 8'h5A;  7'h2D: c = 8'h58;  7'h2E: c = 8'h43;  7'h2F: c = 8'h56;
         7'h30: c = 8'h42;  7'h31: c = 8'h4E;  7'h32: c = 8'h4D;  7'h33: c = 8'h3C;
         7'h34: c = 8'h3E;  7'h35: c = 8'h3F;
         default: c = plain_char(code);
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

@@ src/ps2_scancode_to_ascii_fifo.sv @@
// Channel   Ports                                   Direction
// request   req_valid/req_ready, op, data_ready,    in
//           scancode
// response  rsp_valid/rsp_ready, char_out, flags,   out
//           fifo_level
// csr       csr_we, csr_index, csr_wdata            in (write only)
//
// One transaction per cycle while the response is not stalled; each response appears in the cycle after its request.
// Character store is a single synchronous RAM: push writes at the write pointer,
// pop reads at the read pointer (never in the same cycle as a push).
// Reset is synchronous, with no clearing pass of the store.
// A stalled response holds; a new request is taken in the cycle it is drained.
// Depends on ps2a_pkg.
`default_nettype none

module ps2_scancode_to_ascii_fifo
   import ps2a_pkg::*;
#(
   parameter int FIFO_SLOTS = FIFO_SLOTS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_op,
   input  wire logic       req_data_ready,
   input  wire logic [7:0] req_scancode,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_char_out,
   output logic            rsp_char_valid,
   output logic            rsp_shift_held,
   output logic            rsp_ctrl_held,
   output logic            rsp_alt_held,
   output logic [6:0]      rsp_fifo_level,
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata
);

   localparam int PTR_W = (FIFO_SLOTS > 1) ? $clog2(FIFO_SLOTS) : 1;
   localparam int LVL_W = (PTR_W > 7) ? PTR_W : 7;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(FIFO_SLOTS - 1);

   char_type store [FIFO_SLOTS];
   char_type rd_data_ff;

   logic [PTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in, count_ff, count_in;
   logic             shift_ff, shift_in, ctrl_ff, ctrl_in, alt_ff, alt_in;
   char_type         esc_ff, bksp_ff, tab_ff, enter_ff;

   logic             rsp_valid_ff, rsp_cv_ff, rsp_shift_ff, rsp_ctrl_ff, rsp_alt_ff;
   logic [6:0]       rsp_level_ff;

   logic             accept, is_event, release_bit, is_modifier, push, pop;
   logic [6:0]       code;
   char_type         base_ch, ch;
   logic [LVL_W-1:0] level_wide;

   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign is_event    = (req_op == OP_EVENT) && req_data_ready;
   assign release_bit = req_scancode[7];
   assign code        = req_scancode[6:0];
   assign is_modifier = (code == SC_LSHIFT) || (code == SC_RSHIFT) ||
                        (code == SC_CTRL) || (code == SC_ALT);

   always_comb begin
      case (code)
         SC_ESC:   base_ch = esc_ff;
         SC_BKSP:  base_ch = bksp_ff;
         SC_TAB:   base_ch = tab_ff;
         SC_ENTER: base_ch = enter_ff;
         default:  base_ch = shift_ff ? shift_char(code) : plain_char(code);
      endcase
      // ctrl folds lower-case letters onto 1..26
      if (ctrl_ff && (base_ch >= CH_LOWER_A) && (base_ch <= CH_LOWER_Z)) begin
         ch = base_ch - CH_CTRL_OFFSET;
      end else begin
         ch = base_ch;
      end
   end

   // keep one slot free: full at FIFO_SLOTS-1 characters
   assign push = accept && is_event && !release_bit && !is_modifier &&
                 (ch != 8'h00) && (ch != bksp_ff) && (count_ff != LAST_SLOT);
   assign pop  = accept && (req_op == OP_READ) && (count_ff != '0);

   always_comb begin
      shift_in = shift_ff;
      ctrl_in  = ctrl_ff;
      alt_in   = alt_ff;
      if (accept && is_event) begin
         if ((code == SC_LSHIFT) || (code == SC_RSHIFT)) begin
            shift_in = !release_bit;
         end
         if (code == SC_CTRL) begin
            ctrl_in = !release_bit;
         end
         if (code == SC_ALT) begin
            alt_in = !release_bit;
         end
      end
      wptr_in  = push ? ((wptr_ff == LAST_SLOT) ? '0 : wptr_ff + 1'b1) : wptr_ff;
      rptr_in  = pop ? ((rptr_ff == LAST_SLOT) ? '0 : rptr_ff + 1'b1) : rptr_ff;
      count_in = count_ff;
      if (push) begin
         count_in = count_ff + 1'b1;
      end else if (pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign level_wide = LVL_W'(count_in);

   // character store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (push) begin
         store[wptr_ff] <= ch;
      end
      if (pop) begin
         rd_data_ff <= store[rptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff      <= '0;
         rptr_ff      <= '0;
         count_ff     <= '0;
         shift_ff     <= 1'b0;
         ctrl_ff      <= 1'b0;
         alt_ff       <= 1'b0;
         esc_ff       <= ESCAPE_RST;
         bksp_ff      <= BACKSPACE_RST;
         tab_ff       <= TAB_RST;
         enter_ff     <= ENTER_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
         shift_ff <= shift_in;
         ctrl_ff  <= ctrl_in;
         alt_ff   <= alt_in;
         if (csr_we) begin
            case (csr_index)
               CSR_ESCAPE:    esc_ff   <= csr_wdata;
               CSR_BACKSPACE: bksp_ff  <= csr_wdata;
               CSR_TAB:       tab_ff   <= csr_wdata;
               CSR_ENTER:     enter_ff <= csr_wdata;
               default:       ;
            endcase
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_cv_ff    <= pop;
         rsp_shift_ff <= shift_in;
         rsp_ctrl_ff  <= ctrl_in;
         rsp_alt_ff   <= alt_in;
         rsp_level_ff <= level_wide[6:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_char_out   = rsp_cv_ff ? rd_data_ff : 8'h00;
   assign rsp_char_valid = rsp_cv_ff;
   assign rsp_shift_held = rsp_shift_ff;
   assign rsp_ctrl_held  = rsp_ctrl_ff;
   assign rsp_alt_held   = rsp_alt_ff;
   assign rsp_fifo_level = rsp_level_ff;

endmodule

`default_nettype wire

@@ src/ps2a_checker.sv @@
// Port-level checks for ps2_scancode_to_ascii_fifo, attached by bind.
// Depends on ps2a_pkg.
`default_nettype none

module ps2a_checker
   import ps2a_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_op,
   input wire logic       req_data_ready,
   input wire logic [7:0] req_scancode,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_char_out,
   input wire logic       rsp_char_valid,
   input wire logic       rsp_shift_held,
   input wire logic       rsp_ctrl_held,
   input wire logic       rsp_alt_held,
   input wire logic [6:0] rsp_fifo_level
);

   logic req_take;
   assign req_take = req_valid && req_ready;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_out) &&
      $stable(rsp_char_valid) && $stable(rsp_fifo_level) && $stable(rsp_shift_held))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // an event never yields a character
   a_event_no_char: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_op == OP_EVENT) |=> rsp_valid && !rsp_char_valid &&
      (rsp_char_out == 8'h00))
      else $error("event transaction produced a character");

   a_shift_release: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_op == OP_EVENT) && req_data_ready &&
      (req_scancode == SC_RELEASE_LSHIFT) |=> !rsp_shift_held)
      else $error("shift still held after release");

   // character field is zero unless a read popped one
   a_idle_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_char_valid |-> (rsp_char_out == 8'h00))
      else $error("character reported without a pop");

endmodule

bind ps2_scancode_to_ascii_fifo ps2a_checker u_ps2a_checker (.*);

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for ps2_scancode_to_ascii_fifo: key decoding, modifiers,
// code registers, FIFO fill and drain, and output back-pressure against a local predictor.
// Depends on ps2a_pkg and the ps2_scancode_to_ascii_fifo RTL.
`timescale 1ns / 100ps

module testbench;
   import ps2a_pkg::*;

   localparam int CHAR_CAP    = FIFO_SLOTS_DEF - 1;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [7:0] char_out;
      logic       char_valid;
      logic       shift_held;
      logic       ctrl_held;
      logic       alt_held;
      logic [6:0] fifo_level;
   } key_result_type;

   typedef enum int {RX_STEADY, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_style_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_op;
   logic       req_data_ready;
   logic [7:0] req_scancode;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_char_out;
   logic       rsp_char_valid;
   logic       rsp_shift_held;
   logic       rsp_ctrl_held;
   logic       rsp_alt_held;
   logic [6:0] rsp_fifo_level;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;

   // set-1 key maps; '@' (plain) and '=' (shifted) mark keys with no character
   string plain_keys = {"@@1234567890-=@@", "qwertyuiop[]@@as", "dfghjkl;'@@\\zxcv",
                        "bnm,./@*@ @@@@@@", "@@@@@@@789-456+1", "230."};
   string shifted_keys = {"==!@#$%^&*()_+==", "QWERTYUIOP{}==AS", "DFGHJKL:\"~=|ZXCV",
                          "BNM<>?=*= ======", "=======789-456+1", "230."};
   logic [7:0] plain_map   [128];
   logic [7:0] shifted_map [128];

   // predictor state
   logic [7:0]  esc_char  = ESCAPE_RST;
   logic [7:0]  bksp_char = BACKSPACE_RST;
   logic [7:0]  tab_char  = TAB_RST;
   logic [7:0]  enter_char = ENTER_RST;
   logic        shift_down = 1'b0;
   logic        ctrl_down  = 1'b0;
   logic        alt_down   = 1'b0;
   logic [7:0]  typed_chars [$];
   key_result_type expected_results [$];

   int n_errors      = 0;
   int cycle_count   = 0;
   int tx_burst_left = 0;
   int tx_gap_max    = 3;
   int rx_hold_req   = 0;

   ps2_scancode_to_ascii_fifo uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_data_ready (req_data_ready),
      .req_scancode   (req_scancode),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_char_out   (rsp_char_out),
      .rsp_char_valid (rsp_char_valid),
      .rsp_shift_held (rsp_shift_held),
      .rsp_ctrl_held  (rsp_ctrl_held),
      .rsp_alt_held   (rsp_alt_held),
      .rsp_fifo_level (rsp_fifo_level),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic key_result_type decode_key(input logic op, input logic dr,
                                                 input logic [7:0] sc);
      key_result_type r;
      logic [6:0]  code;
      logic        brk;
      logic [7:0]  ch;
      r = '0;
      code = sc[6:0];
      brk = sc[7];
      ch = 8'h00;
      if (op == OP_EVENT) begin
         if (dr) begin
            if (code == SC_LSHIFT || code == SC_RSHIFT) shift_down = !brk;
            else if (code == SC_CTRL) ctrl_down = !brk;
            else if (code == SC_ALT) alt_down = !brk;
            else if (!brk) begin
               case (code)
                  SC_ESC:   ch = esc_char;
                  SC_BKSP:  ch = bksp_char;
                  SC_TAB:   ch = tab_char;
                  SC_ENTER: ch = enter_char;
                  default:  ch = shift_down ? shifted_map[code] : plain_map[code];
               endcase
               if (ctrl_down && ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
                  ch = ch - CH_CTRL_OFFSET;
               // one slot always kept free, so a push into CHAR_CAP chars is lost
               if (ch != 8'h00 && ch != bksp_char && typed_chars.size() < CHAR_CAP)
                  typed_chars.push_back(ch);
            end
         end
      end else if (typed_chars.size() != 0) begin
         r.char_out = typed_chars.pop_front();
         r.char_valid = 1'b1;
      end
      r.shift_held = shift_down;
      r.ctrl_held = ctrl_down;
      r.alt_held = alt_down;
      r.fifo_level = 7'(typed_chars.size());
      return r;
   endfunction

   function automatic void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         n_errors++;
      end
   endfunction

   always @(posedge clock) begin
      key_result_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_results.size() == 0) begin
            $error("response transaction with no request outstanding");
            n_errors++;
         end else begin
            want = expected_results.pop_front();
            compare_field("char_out", want.char_out, rsp_char_out);
            compare_field("char_valid", want.char_valid, rsp_char_valid);
            compare_field("shift_held", want.shift_held, rsp_shift_held);
            compare_field("ctrl_held", want.ctrl_held, rsp_ctrl_held);
            compare_field("alt_held", want.alt_held, rsp_alt_held);
            compare_field("fifo_level", want.fifo_level, rsp_fifo_level);
         end
      end
   end

   // receiver: stall style is picked anew at random; long holds on request
   initial begin
      rx_style_type rx_style;
      int        style_left;
      int        hold_left;
      rsp_ready = 1'b0;
      style_left = 0;
      hold_left = 0;
      rx_style = RX_STEADY;
      forever begin
         @(negedge clock);
         if (rx_hold_req != 0) begin
            hold_left = rx_hold_req;
            rx_hold_req = 0;
         end
         if (style_left == 0) begin
            rx_style = rx_style_type'($urandom_range(0, 3));
            style_left = $urandom_range(20, 120);
         end
         style_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (rx_style)
               RX_STEADY:   rsp_ready <= 1'b1;
               RX_LIGHT:    rsp_ready <= ($urandom_range(0, 3) != 0);
               RX_PERIODIC: rsp_ready <= (style_left % 3 == 0);
               default:     rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // one request transaction; bursts end in a random gap with valid low
   task automatic press(input logic op, input logic dr, input logic [7:0] sc);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_op <= op;
      req_data_ready <= dr;
      req_scancode <= sc;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      expected_results.push_back(decode_key(op, dr, sc));
      if (tx_burst_left > 0) begin
         tx_burst_left--;
      end else begin
         tx_burst_left = $urandom_range(0, 15);
         gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_ESCAPE:    esc_char = val;
         CSR_BACKSPACE: bksp_char = val;
         CSR_TAB:       tab_char = val;
         default:       enter_char = val;
      endcase
   endtask

   task automatic set_codes(input logic [7:0] esc, input logic [7:0] bksp,
                            input logic [7:0] tab, input logic [7:0] enter);
      wait_drained();
      write_csr(CSR_ESCAPE, esc);
      write_csr(CSR_BACKSPACE, bksp);
      write_csr(CSR_TAB, tab);
      write_csr(CSR_ENTER, enter);
   endtask

   task automatic random_keystroke(input int read_pct, output bit counted);
      int         pick;
      logic [6:0] code;
      pick = $urandom_range(0, 99);
      counted = 1'b1;
      if (pick < read_pct) begin
         press(OP_READ, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else if (pick < read_pct + 12) begin
         case ($urandom_range(0, 3))
            0:       code = SC_LSHIFT;
            1:       code = SC_RSHIFT;
            2:       code = SC_CTRL;
            default: code = SC_ALT;
         endcase
         press(OP_EVENT, 1'b1, {($urandom_range(0, 9) < 6), code});
      end else if (pick < 93) begin
         code = 7'($urandom_range(1, 8'h53));
         press(OP_EVENT, 1'b1, {1'b0, code});
         if ($urandom_range(0, 9) < 4) press(OP_EVENT, 1'b1, {1'b1, code});
      end else if (pick < 97) begin
         press(OP_EVENT, 1'b1, 8'($urandom_range(0, 255)));
      end else begin
         // not ready: the block should ignore it
         press(OP_EVENT, 1'b0, 8'($urandom_range(0, 255)));
         counted = 1'b0;
      end
   endtask

   task automatic test_idle_reads();
      press(OP_READ, 1'b1, 8'hFF);
      press(OP_READ, 1'b0, 8'h00);
      press(OP_EVENT, 1'b0, 8'h1E);
      press(OP_EVENT, 1'b0, {1'b0, SC_LSHIFT});
   endtask

   task automatic test_modifiers();
      press(OP_EVENT, 1'b1, {1'b0, SC_LSHIFT});
      press(OP_EVENT, 1'b1, {1'b0, SC_RSHIFT});
      press(OP_EVENT, 1'b1, {1'b1, SC_RSHIFT});   // either shift release clears the flag
      press(OP_EVENT, 1'b1, {1'b0, SC_CTRL});
      press(OP_EVENT, 1'b1, {1'b0, SC_ALT});
      press(OP_EVENT, 1'b1, 8'h9E);
      press(OP_EVENT, 1'b1, {1'b1, SC_CTRL});
      press(OP_EVENT, 1'b1, {1'b1, SC_ALT});
   endtask

   task automatic test_key_lookup();
      press(OP_EVENT, 1'b1, 8'h1E);
      press(OP_EVENT, 1'b1, {1'b0, SC_LSHIFT});
      press(OP_EVENT, 1'b1, 8'h1E);
      press(OP_EVENT, 1'b1, 8'h03);
      press(OP_EVENT, 1'b1, SC_RELEASE_LSHIFT);
      press(OP_EVENT, 1'b1, {1'b0, SC_CTRL});
      press(OP_EVENT, 1'b1, 8'h23);               // ctrl-h equals backspace, dropped
      press(OP_EVENT, 1'b1, 8'h2C);
      press(OP_EVENT, 1'b1, {1'b1, SC_CTRL});
      press(OP_EVENT, 1'b1, {1'b0, SC_ESC});
      press(OP_EVENT, 1'b1, {1'b0, SC_BKSP});
      press(OP_EVENT, 1'b1, {1'b0, SC_TAB});
      press(OP_EVENT, 1'b1, {1'b0, SC_ENTER});
      press(OP_EVENT, 1'b1, 8'h7F);
      press(OP_EVENT, 1'b1, 8'h00);
      press(OP_EVENT, 1'b1, 8'h80);
      repeat (8) press(OP_READ, 1'b1, 8'h00);
   endtask

   task automatic test_code_registers();
      set_codes(8'h63, 8'h03, 8'h00, 8'hFF);
      press(OP_EVENT, 1'b1, {1'b0, SC_CTRL});
      press(OP_EVENT, 1'b1, {1'b0, SC_ESC});      // 'c' under ctrl hits backspace code
      press(OP_EVENT, 1'b1, {1'b0, SC_TAB});
      press(OP_EVENT, 1'b1, {1'b0, SC_ENTER});
      press(OP_EVENT, 1'b1, 8'h23);
      press(OP_EVENT, 1'b1, {1'b1, SC_CTRL});
      press(OP_EVENT, 1'b1, {1'b0, SC_ESC});
      repeat (4) press(OP_READ, 1'b1, 8'h00);
      set_codes(8'hFF, 8'hFF, 8'h7A, 8'h00);
      press(OP_EVENT, 1'b1, {1'b0, SC_BKSP});
      press(OP_EVENT, 1'b1, {1'b0, SC_ESC});
      press(OP_EVENT, 1'b1, {1'b0, SC_TAB});
      press(OP_EVENT, 1'b1, {1'b0, SC_ENTER});
      repeat (2) press(OP_READ, 1'b1, 8'h00);
   endtask

   task automatic test_fifo_full();
      set_codes(ESCAPE_RST, BACKSPACE_RST, TAB_RST, ENTER_RST);
      tx_gap_max = 0;
      repeat (CHAR_CAP + 8) press(OP_EVENT, 1'b1, 8'($urandom_range(8'h10, 8'h19)));
      tx_gap_max = 2;
      repeat (CHAR_CAP + 3) press(OP_READ, 1'($urandom_range(0, 1)), 8'h00);
   endtask

   task automatic test_backpressure();
      bit counted;
      wait_drained();
      tx_gap_max = 0;
      rx_hold_req = 300;
      repeat (40) random_keystroke(40, counted);
   endtask

   task automatic test_random_typing();
      int read_pct;
      int n_keys;
      bit counted;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_codes(ESCAPE_RST, BACKSPACE_RST, TAB_RST, ENTER_RST);
            1: set_codes(8'h00, 8'h00, 8'h00, 8'h00);
            2: set_codes(8'hFF, 8'hFF, 8'hFF, 8'hFF);
            3: set_codes(8'($urandom_range(CH_LOWER_A, CH_LOWER_Z)),
                         8'($urandom_range(CH_LOWER_A, CH_LOWER_Z)),
                         8'($urandom_range(CH_LOWER_A, CH_LOWER_Z)),
                         8'($urandom_range(CH_LOWER_A, CH_LOWER_Z)));
            default: set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         endcase
         case (phase)
            0:       read_pct = 30;
            1:       read_pct = 45;
            2:       read_pct = 20;
            3:       read_pct = 55;
            default: read_pct = 40;
         endcase
         tx_gap_max = (phase % 2 == 0) ? 6 : 0;
         n_keys = 0;
         while (n_keys < 25) begin
            random_keystroke(read_pct, counted);
            if (counted) n_keys++;
         end
      end
   endtask

   initial begin
      for (int i = 0; i < 128; i++) begin
         plain_map[i] = (i < plain_keys.len() && plain_keys[i] != "@") ? plain_keys[i] : 8'h00;
         shifted_map[i] = (i < shifted_keys.len() && shifted_keys[i] != "=") ?
                          shifted_keys[i] : 8'h00;
      end
      plain_map[8'h29] = 8'h60;   // grave accent kept out of the string
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_EVENT;
      req_data_ready = 1'b0;
      req_scancode = 8'h00;
      csr_we = 1'b0;
      csr_index = CSR_ESCAPE;
      csr_wdata = 8'h00;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_reads();
      test_modifiers();
      test_key_lookup();
      test_code_registers();
      test_fifo_full();
      test_backpressure();
      test_random_typing();

      wait_drained();
      repeat (8) @(posedge clock);
      if (n_errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ filelist.f @@
src/ps2a_pkg.sv
src/ps2_scancode_to_ascii_fifo.sv
src/ps2a_checker.sv
tb/testbench.sv
